FILE: hdl/nmi_pkg.sv
// Shared constants for the normalized mutual information block.
`timescale 1ns / 1ps
`default_nettype none
package nmi_pkg;
    // Parameter defaults
    localparam int DEF_MAX_STATES  = 64;
    localparam int DEF_MAX_SAMPLES = 65536;
    localparam int DEF_FRAC_BITS   = 16;

    // Fixed port widths
    localparam int LABEL_W = 7;
    localparam int NMI_W   = 17;
    localparam int TOTAL_W = 17;

    // Quotient fraction bits of the result
    localparam int OUT_FRAC = 16;

    // Log2 mantissa is Q1.31 in a 32-bit word, exponent counts down from 31
    localparam int MANT_W = 32;
    localparam int EXP_W  = 5;
endpackage
`default_nettype wire

FILE: hdl/nmi_log2.sv
// Iterative x*log2(x) unit: normalize, square per fraction bit, final multiply.
`timescale 1ns / 1ps
`default_nettype none
module nmi_log2 #(
    parameter int CW        = 17,
    parameter int FRAC_BITS = 16,
    parameter int PW        = CW + $clog2(CW) + FRAC_BITS
) (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          start,
    input  wire logic [CW-1:0] x,
    output logic               done,
    output logic [PW-1:0]      xlogx
);
    import nmi_pkg::*;

    localparam int EW  = $clog2(CW);
    localparam int LW  = EW + FRAC_BITS;
    localparam int CNW = $clog2(FRAC_BITS);

    localparam logic [1:0] LG_IDLE = 2'd0;
    localparam logic [1:0] LG_NORM = 2'd1;
    localparam logic [1:0] LG_SQ   = 2'd2;
    localparam logic [1:0] LG_MUL  = 2'd3;

    logic [1:0]           state_reg;
    logic [CW-1:0]        x_reg;
    logic [MANT_W-1:0]    m_reg;
    logic [EXP_W-1:0]     e_reg;
    logic [FRAC_BITS-1:0] frac_reg;
    logic [CNW-1:0]       cnt_reg;
    logic                 done_reg;
    logic [PW-1:0]        prod_reg;

    logic [2*MANT_W-1:0]  sq;
    logic [MANT_W:0]      sq_hi;
    logic [LW-1:0]        lval;

    // Square the mantissa and keep Q1.31 plus one overflow bit
    assign sq    = {{MANT_W{1'b0}}, m_reg} * {{MANT_W{1'b0}}, m_reg};
    assign sq_hi = sq[2*MANT_W-1:MANT_W-1];
    assign lval  = {e_reg[EW-1:0], frac_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= LG_IDLE;
            done_reg  <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            unique case (state_reg)
                LG_IDLE: begin
                    if (start) begin
                        x_reg     <= x;
                        m_reg     <= MANT_W'(x);
                        e_reg     <= EXP_W'(MANT_W - 1);
                        state_reg <= LG_NORM;
                    end
                end
                // one bit of left shift per cycle until the leading one is at the top
                LG_NORM: begin
                    if (m_reg[MANT_W-1]) begin
                        cnt_reg   <= '0;
                        state_reg <= LG_SQ;
                    end else begin
                        m_reg <= {m_reg[MANT_W-2:0], 1'b0};
                        e_reg <= e_reg - 1'b1;
                    end
                end
                // one fraction bit per cycle, MSB first
                LG_SQ: begin
                    frac_reg <= {frac_reg[FRAC_BITS-2:0], sq_hi[MANT_W]};
                    m_reg    <= sq_hi[MANT_W] ? sq_hi[MANT_W:1] : sq_hi[MANT_W-1:0];
                    cnt_reg  <= cnt_reg + 1'b1;
                    if (cnt_reg == CNW'(FRAC_BITS - 1)) begin
                        state_reg <= LG_MUL;
                    end
                end
                LG_MUL: begin
                    prod_reg  <= PW'(x_reg) * PW'(lval);
                    done_reg  <= 1'b1;
                    state_reg <= LG_IDLE;
                end
                default: state_reg <= LG_IDLE;
            endcase
        end
    end

    assign done  = done_reg;
    assign xlogx = prod_reg;
endmodule
`default_nettype wire

FILE: hdl/nmi_div.sv
// Restoring divider, one quotient bit per cycle, for num < den.
`timescale 1ns / 1ps
`default_nettype none
module nmi_div #(
    parameter int NW = 40
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          start,
    input  wire logic [NW-1:0]                 num,
    input  wire logic [NW-1:0]                 den,
    output logic                               done,
    output logic [nmi_pkg::OUT_FRAC-1:0]       quot
);
    import nmi_pkg::*;

    localparam int CNW = $clog2(OUT_FRAC);

    logic              busy_reg;
    logic              done_reg;
    logic [NW:0]       rem_reg;
    logic [NW-1:0]     den_reg;
    logic [OUT_FRAC-1:0] q_reg;
    logic [CNW-1:0]    cnt_reg;

    logic [NW:0]       rem2;
    logic              ge;

    assign rem2 = {rem_reg[NW-1:0], 1'b0};
    assign ge   = rem2 >= {1'b0, den_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            if (start && !busy_reg) begin
                rem_reg  <= {1'b0, num};
                den_reg  <= den;
                q_reg    <= '0;
                cnt_reg  <= '0;
                busy_reg <= 1'b1;
            end else if (busy_reg) begin
                rem_reg <= ge ? rem2 - {1'b0, den_reg} : rem2;
                q_reg   <= {q_reg[OUT_FRAC-2:0], ge};
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CNW'(OUT_FRAC - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign done = done_reg;
    assign quot = q_reg;
endmodule
`default_nettype wire

FILE: hdl/normalized_mutual_information.sv
// Top level: count label pairs, then walk the tables and form the NMI.
//
// Input channel (s_valid/s_ready) takes one request per sample: feature and
// class labels, 1-based, plus s_last that closes the set. Labels outside
// 1..MAX_STATES are not counted; s_last still takes effect.
// Output channel (m_valid/m_ready) carries one result per set: nmi in Q1.16,
// the sample count and the overflow flag.
// Each sample passes through a table read, then a read-modify-write of the
// joint, row and column counts. The final sample starts a table walk over
// the 4^IW joint entries plus 2*MAX_STATES row and column entries, with a
// pass of the shared log2 unit for each nonzero count x and for the total,
// then a division when the ratio lies strictly between zero and one.
// The walk also clears the tables for the next set.
// After reset the block sweeps the 4^IW joint entries once (4096 at the
// defaults) with s_ready low.
// A finished result sits in the output register; new samples are taken
// while it waits. A further result waits until the previous one is taken.
`timescale 1ns / 1ps
`default_nettype none
module normalized_mutual_information #(
    parameter int MAX_STATES  = nmi_pkg::DEF_MAX_STATES,
    parameter int MAX_SAMPLES = nmi_pkg::DEF_MAX_SAMPLES,
    parameter int FRAC_BITS   = nmi_pkg::DEF_FRAC_BITS
) (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic                        s_valid,
    output logic                             s_ready,
    input  wire logic [nmi_pkg::LABEL_W-1:0] s_feature_label,
    input  wire logic [nmi_pkg::LABEL_W-1:0] s_class_label,
    input  wire logic                        s_last,
    output logic                             m_valid,
    input  wire logic                        m_ready,
    output logic [nmi_pkg::NMI_W-1:0]        m_nmi,
    output logic [nmi_pkg::TOTAL_W-1:0]      m_sample_total,
    output logic                             m_overflow
);
    import nmi_pkg::*;

    localparam int IW = $clog2(MAX_STATES);
    localparam int JW = 2 * IW;
    localparam int JD = 1 << JW;
    localparam int CW = $clog2(MAX_SAMPLES + 1);
    localparam int LW = $clog2(CW) + FRAC_BITS;
    localparam int SW = CW + LW;
    localparam int NW = SW + 2;

    localparam logic [3:0] S_CLR  = 4'd0;
    localparam logic [3:0] S_IDLE = 4'd1;
    localparam logic [3:0] S_UPD  = 4'd2;
    localparam logic [3:0] S_WRD  = 4'd3;
    localparam logic [3:0] S_WCHK = 4'd4;
    localparam logic [3:0] S_WLOG = 4'd5;
    localparam logic [3:0] S_TOT  = 4'd6;
    localparam logic [3:0] S_TOTW = 4'd7;
    localparam logic [3:0] S_CALC = 4'd8;
    localparam logic [3:0] S_DEC  = 4'd9;
    localparam logic [3:0] S_DIV  = 4'd10;
    localparam logic [3:0] S_FIN  = 4'd11;

    localparam logic [1:0] PH_JOINT = 2'd0;
    localparam logic [1:0] PH_ROW   = 2'd1;
    localparam logic [1:0] PH_COL   = 2'd2;

    // Count memories
    logic [CW-1:0] joint_mem [JD];
    logic [CW-1:0] row_mem [MAX_STATES];
    logic [CW-1:0] col_mem [MAX_STATES];
    logic [CW-1:0] joint_q, row_q, col_q;

    logic [3:0]    state_reg;
    logic [1:0]    phase_reg;
    logic [JW-1:0] idx_reg;
    logic [IW-1:0] fi_reg, ci_reg;
    logic          upd_reg, last_reg;
    logic [CW-1:0] total_reg;
    logic          sat_reg;
    logic [SW-1:0] sc_reg, sr_reg, sk_reg, nl_reg;
    logic signed [NW-1:0] num_reg, den_reg;
    logic [NMI_W-1:0] q_reg;
    logic          m_valid_reg;
    logic [NMI_W-1:0]   nmi_reg;
    logic [TOTAL_W-1:0] tot_out_reg;
    logic          ovf_reg;

    logic          accept, lab_ok, total_full;
    logic [IW-1:0] fidx, cidx;
    logic [JW-1:0] joint_raddr, joint_waddr;
    logic [IW-1:0] row_raddr, col_raddr, row_waddr, col_waddr;
    logic          joint_we, row_we, col_we;
    logic [CW-1:0] joint_wdata, row_wdata, col_wdata;
    logic [CW-1:0] walk_q;
    logic          walk_end;
    logic          log_start, log_done;
    logic [CW-1:0] log_x;
    logic [SW-1:0] log_val;
    logic          div_start, div_done;
    logic [OUT_FRAC-1:0] div_q;
    logic [SW-1:0] min_rk;
    logic          out_free;

    // Request decode
    assign accept = s_valid && s_ready;
    assign lab_ok = (s_feature_label != '0) && (32'(s_feature_label) <= MAX_STATES) &&
                    (s_class_label != '0) && (32'(s_class_label) <= MAX_STATES);
    assign fidx = IW'(32'(s_feature_label) - 32'd1);
    assign cidx = IW'(32'(s_class_label) - 32'd1);
    assign total_full = (total_reg >= CW'(MAX_SAMPLES));

    // Memory addressing
    assign joint_raddr = (state_reg == S_IDLE) ? {fidx, cidx} : idx_reg;
    assign row_raddr   = (state_reg == S_IDLE) ? fidx : idx_reg[IW-1:0];
    assign col_raddr   = (state_reg == S_IDLE) ? cidx : idx_reg[IW-1:0];

    assign joint_we = (state_reg == S_CLR) || (state_reg == S_UPD && upd_reg) ||
                      (state_reg == S_WCHK && phase_reg == PH_JOINT);
    assign row_we   = (state_reg == S_CLR) || (state_reg == S_UPD && upd_reg) ||
                      (state_reg == S_WCHK && phase_reg == PH_ROW);
    assign col_we   = (state_reg == S_CLR) || (state_reg == S_UPD && upd_reg) ||
                      (state_reg == S_WCHK && phase_reg == PH_COL);
    assign joint_waddr = (state_reg == S_UPD) ? {fi_reg, ci_reg} : idx_reg;
    assign row_waddr   = (state_reg == S_UPD) ? fi_reg : idx_reg[IW-1:0];
    assign col_waddr   = (state_reg == S_UPD) ? ci_reg : idx_reg[IW-1:0];
    assign joint_wdata = (state_reg == S_UPD) ? joint_q + 1'b1 : '0;
    assign row_wdata   = (state_reg == S_UPD) ? row_q + 1'b1 : '0;
    assign col_wdata   = (state_reg == S_UPD) ? col_q + 1'b1 : '0;

    always_ff @(posedge aclk) begin
        if (joint_we) begin
            joint_mem[joint_waddr] <= joint_wdata;
        end
        joint_q <= joint_mem[joint_raddr];
    end

    always_ff @(posedge aclk) begin
        if (row_we) begin
            row_mem[row_waddr] <= row_wdata;
        end
        row_q <= row_mem[row_raddr];
    end

    always_ff @(posedge aclk) begin
        if (col_we) begin
            col_mem[col_waddr] <= col_wdata;
        end
        col_q <= col_mem[col_raddr];
    end

    // Walk data and end of the current table
    always_comb begin
        unique case (phase_reg)
            PH_JOINT: walk_q = joint_q;
            PH_ROW:   walk_q = row_q;
            default:  walk_q = col_q;
        endcase
    end
    assign walk_end = (phase_reg == PH_JOINT) ? (idx_reg == JW'(JD - 1)) :
                      (idx_reg == JW'(MAX_STATES - 1));

    // Shared log unit
    assign log_start = ((state_reg == S_WCHK) && (walk_q != '0)) ||
                       ((state_reg == S_TOT) && (total_reg != '0));
    assign log_x     = (state_reg == S_TOT) ? total_reg : walk_q;

    nmi_log2 #(
        .CW        (CW),
        .FRAC_BITS (FRAC_BITS),
        .PW        (SW)
    ) u_log2 (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (log_start),
        .x       (log_x),
        .done    (log_done),
        .xlogx   (log_val)
    );

    assign div_start = (state_reg == S_DEC) && (num_reg > 0) && (den_reg > 0) &&
                       (num_reg < den_reg);

    nmi_div #(
        .NW (NW - 1)
    ) u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .num     (num_reg[NW-2:0]),
        .den     (den_reg[NW-2:0]),
        .done    (div_done),
        .quot    (div_q)
    );

    assign min_rk   = (sr_reg < sk_reg) ? sr_reg : sk_reg;
    assign out_free = !m_valid_reg || m_ready;

    // Sequencer
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_CLR;
            phase_reg   <= PH_JOINT;
            idx_reg     <= '0;
            upd_reg     <= 1'b0;
            last_reg    <= 1'b0;
            total_reg   <= '0;
            sat_reg     <= 1'b0;
            sc_reg      <= '0;
            sr_reg      <= '0;
            sk_reg      <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            // result taken; a result finishing now reloads it below
            if (m_valid_reg && m_ready && state_reg != S_FIN) begin
                m_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                // clear the tables once after reset
                S_CLR: begin
                    idx_reg <= idx_reg + 1'b1;
                    if (idx_reg == JW'(JD - 1)) begin
                        state_reg <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (accept) begin
                        fi_reg    <= fidx;
                        ci_reg    <= cidx;
                        upd_reg   <= lab_ok && !total_full;
                        last_reg  <= s_last;
                        if (lab_ok && total_full) begin
                            sat_reg <= 1'b1;
                        end
                        state_reg <= S_UPD;
                    end
                end
                S_UPD: begin
                    if (upd_reg) begin
                        total_reg <= total_reg + 1'b1;
                    end
                    idx_reg   <= '0;
                    phase_reg <= PH_JOINT;
                    state_reg <= last_reg ? S_WRD : S_IDLE;
                end
                S_WRD: begin
                    state_reg <= S_WCHK;
                end
                S_WCHK, S_WLOG: begin
                    if (state_reg == S_WCHK && walk_q != '0) begin
                        state_reg <= S_WLOG;
                    end else if (state_reg == S_WCHK || log_done) begin
                        if (state_reg == S_WLOG) begin
                            unique case (phase_reg)
                                PH_JOINT: sc_reg <= sc_reg + log_val;
                                PH_ROW:   sr_reg <= sr_reg + log_val;
                                default:  sk_reg <= sk_reg + log_val;
                            endcase
                        end
                        if (walk_end) begin
                            idx_reg <= '0;
                            if (phase_reg == PH_COL) begin
                                state_reg <= S_TOT;
                            end else begin
                                phase_reg <= phase_reg + 1'b1;
                                state_reg <= S_WRD;
                            end
                        end else begin
                            idx_reg   <= idx_reg + 1'b1;
                            state_reg <= S_WRD;
                        end
                    end
                end
                S_TOT: begin
                    if (total_reg == '0) begin
                        nl_reg    <= '0;
                        state_reg <= S_CALC;
                    end else begin
                        state_reg <= S_TOTW;
                    end
                end
                S_TOTW: begin
                    if (log_done) begin
                        nl_reg    <= log_val;
                        state_reg <= S_CALC;
                    end
                end
                S_CALC: begin
                    num_reg <= $signed({2'b00, sc_reg}) - $signed({2'b00, sr_reg}) -
                               $signed({2'b00, sk_reg}) + $signed({2'b00, nl_reg});
                    den_reg <= $signed({2'b00, nl_reg}) - $signed({2'b00, min_rk});
                    state_reg <= S_DEC;
                end
                S_DEC: begin
                    if (num_reg <= 0 || den_reg <= 0) begin
                        q_reg     <= '0;
                        state_reg <= S_FIN;
                    end else if (num_reg >= den_reg) begin
                        q_reg     <= NMI_W'(1) << OUT_FRAC;
                        state_reg <= S_FIN;
                    end else begin
                        state_reg <= S_DIV;
                    end
                end
                S_DIV: begin
                    if (div_done) begin
                        q_reg     <= NMI_W'(div_q);
                        state_reg <= S_FIN;
                    end
                end
                S_FIN: begin
                    if (out_free) begin
                        m_valid_reg <= 1'b1;
                        nmi_reg     <= q_reg;
                        tot_out_reg <= TOTAL_W'(total_reg);
                        ovf_reg     <= sat_reg;
                        total_reg   <= '0;
                        sat_reg     <= 1'b0;
                        sc_reg      <= '0;
                        sr_reg      <= '0;
                        sk_reg      <= '0;
                        state_reg   <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign s_ready        = (state_reg == S_IDLE);
    assign m_valid        = m_valid_reg;
    assign m_nmi          = nmi_reg;
    assign m_sample_total = tot_out_reg;
    assign m_overflow     = ovf_reg;
endmodule
`default_nettype wire

FILE: hdl/nmi_check.sv
// Port-level assertions for the NMI block, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
module nmi_check (
    input wire logic                        aclk,
    input wire logic                        aresetn,
    input wire logic                        s_valid,
    input wire logic                        s_ready,
    input wire logic                        m_valid,
    input wire logic                        m_ready,
    input wire logic [nmi_pkg::NMI_W-1:0]   m_nmi,
    input wire logic [nmi_pkg::TOTAL_W-1:0] m_sample_total
);
    // No result right after reset
    assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("result valid after reset");

    // Result never exceeds 1.0
    assert property (@(posedge aclk) disable iff (!aresetn) m_valid |-> m_nmi <= 17'd65536)
        else $error("nmi above one");

    // An empty set reports zero information
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_sample_total == '0) |-> m_nmi == '0)
        else $error("nonzero nmi for empty set");

    // A stalled result holds
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_nmi)))
        else $error("stalled result changed");

    // A new result only appears while no sample request is being taken
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !$rose(m_valid))
        else $error("result appeared right after a sample");
endmodule

bind normalized_mutual_information nmi_check u_nmi_check (.*);
`default_nettype wire
